>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Plain condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, (cond), msg)

`endif

>>> rtl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// Convex polygon check package
// Sizes, types and status codes shared by the convex polygon check modules.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned COORD_BITS   = 24;
  localparam int unsigned AREA_W       = 54;
  localparam int unsigned STATUS_W     = 3;

  localparam int unsigned OP_W   = COORD_BITS + 1;
  localparam int unsigned PROD_W = 2 * OP_W;
  localparam int unsigned TERM_W = PROD_W + 1;
  localparam int unsigned IDX_W  = $clog2(MAX_VERTICES + 2);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OP_W-1:0]       op_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [TERM_W-1:0]     term_t;
  typedef logic signed [AREA_W-1:0]     area_t;
  typedef logic [IDX_W-1:0]             idx_t;

  localparam idx_t NONE_IDX     = '1;
  localparam idx_t MIN_VERTICES = IDX_W'(3);
  localparam idx_t MAX_COUNT    = IDX_W'(MAX_VERTICES);
  localparam idx_t SAT_COUNT    = IDX_W'(MAX_VERTICES + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID      = 3'd0,
    ST_TOO_FEW    = 3'd1,
    ST_ZERO_AREA  = 3'd2,
    ST_COLLINEAR  = 3'd3,
    ST_NOT_CONVEX = 3'd4,
    ST_TOO_MANY   = 3'd5
  } cpc_status_e;

  typedef struct packed {
    logic clear;
    logic note;
    idx_t idx;
    logic flat;
    logic positive;
  } cpc_note_t;

endpackage

>>> rtl/cpc_msub.sv
// ----------------------------------------------------------------------------
// Shared multiply-subtract unit
// Forms a*b - c*d with one signed multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpc_msub import cpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  op_t   a_i,
  input  op_t   b_i,
  input  op_t   c_i,
  input  op_t   d_i,
  output logic  done_o,
  output term_t diff_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SECOND,
    PH_SUB
  } phase_e;

  phase_e phase_q, phase_d;
  logic   done_q, done_d;
  prod_t  prod_q;
  term_t  acc_q;
  op_t    mul_x, mul_y;
  prod_t  mul_p;

  assign mul_x = (phase_q == PH_IDLE) ? a_i : c_i;
  assign mul_y = (phase_q == PH_IDLE) ? b_i : d_i;
  assign mul_p = mul_x * mul_y;

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d = PH_SECOND;
        end
      end
      PH_SECOND: begin
        phase_d = PH_SUB;
      end
      PH_SUB: begin
        phase_d = PH_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      PH_IDLE: begin
        prod_q <= mul_p;
      end
      PH_SECOND: begin
        acc_q  <= TERM_W'(prod_q);
        prod_q <= mul_p;
      end
      PH_SUB: begin
        acc_q <= acc_q - TERM_W'(prod_q);
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign done_o = done_q;
  assign diff_o = acc_q;

  `ASSERT_PROP(a_start_idle, clk_i, rst_ni, start_i |-> (phase_q == PH_IDLE),
    "multiply-subtract started while busy")
  `ASSERT_PROP(a_done_after_sub, clk_i, rst_ni, done_q |-> ($past(phase_q) == PH_SUB),
    "done raised outside the subtract step")
  `ASSERT_PROP(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q,
    "done held for more than one cycle")

endmodule

>>> rtl/cpc_track.sv
// ----------------------------------------------------------------------------
// Cross product sign tracker
// Keeps the first vertex index with a flat, a positive and a negative turn.
// ----------------------------------------------------------------------------
module cpc_track import cpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cpc_note_t note_i,
  output idx_t      flat_idx_o,
  output idx_t      pos_idx_o,
  output idx_t      neg_idx_o
);

  idx_t flat_q, flat_d;
  idx_t pos_q, pos_d;
  idx_t neg_q, neg_d;

  always_comb begin
    flat_d = flat_q;
    pos_d  = pos_q;
    neg_d  = neg_q;
    if (note_i.clear) begin
      flat_d = NONE_IDX;
      pos_d  = NONE_IDX;
      neg_d  = NONE_IDX;
    end else if (note_i.note) begin
      if (note_i.flat) begin
        if (flat_q == NONE_IDX) begin
          flat_d = note_i.idx;
        end
      end else if (note_i.positive) begin
        if (pos_q == NONE_IDX) begin
          pos_d = note_i.idx;
        end
      end else begin
        if (neg_q == NONE_IDX) begin
          neg_d = note_i.idx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_q <= NONE_IDX;
      pos_q  <= NONE_IDX;
      neg_q  <= NONE_IDX;
    end else begin
      flat_q <= flat_d;
      pos_q  <= pos_d;
      neg_q  <= neg_d;
    end
  end

  assign flat_idx_o = flat_q;
  assign pos_idx_o  = pos_q;
  assign neg_idx_o  = neg_q;

endmodule

>>> rtl/convex_polygon_check.sv
// Each vertex after the first adds an area term, each after the second also a
// cross product, and the last vertex adds the closing terms before the result is
// registered. The pace is set by the single 25x25 multiplier, which forms the
// two products of every area term and cross product in turn.
// Reset clears the vertex count, area sum and index trackers; the block is
// ready for a vertex in the first cycle after reset.
// ----------------------------------------------------------------------------
// Convex polygon check
// Streams polygon vertices, sums the doubled shoelace area and classifies the
// turn at every vertex, then reports one status per polygon.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module convex_polygon_check import cpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  coord_t              x_coord_i,
  input  coord_t              z_coord_i,
  input  logic                last_vertex_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output area_t               area_twice_o,
  output logic                counter_clockwise_o
);

  localparam int unsigned SUM_W = ((TERM_W > AREA_W) ? TERM_W : AREA_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_COMMIT,
    S_FINISH,
    S_VERDICT
  } state_e;

  typedef enum logic [2:0] {
    OP_AREA_EDGE,
    OP_CROSS_MID,
    OP_AREA_CLOSE,
    OP_CROSS_LAST,
    OP_CROSS_FIRST
  } op_e;

  state_e      state_q, state_d;
  op_e         opk_q, opk_d;
  logic        start_q, start_d;
  idx_t        count_q, count_d;
  area_t       area_q, area_d;
  logic        c0_flat_q, c0_flat_d;
  logic        c0_pos_q, c0_pos_d;
  logic        out_valid_q, out_valid_d;
  cpc_status_e status_q, status_d;
  area_t       area_out_q, area_out_d;
  logic        ccw_q, ccw_d;

  coord_t in_x_q, in_z_q;
  logic   last_q;
  coord_t first_x_q, first_z_q, second_x_q, second_z_q;
  coord_t older_x_q, older_z_q, newer_x_q, newer_z_q;
  op_t    op_a_q, op_b_q, op_c_q, op_d_q;
  op_t    op_a_d, op_b_d, op_c_d, op_d_d;
  coord_t cur_x, cur_z, nxt_x, nxt_z, prv_x, prv_z;

  logic        in_accept;
  logic        emit_ok;
  logic        msub_done;
  term_t       msub_diff;
  logic        diff_flat, diff_pos;
  logic signed [SUM_W-1:0] area_sum_full;
  logic [SUM_W-AREA_W:0]   sum_top;
  area_t       area_sat;
  cpc_note_t   note;
  idx_t        flat_idx, pos_idx, neg_idx, opp_idx;
  cpc_status_e verdict;
  logic        area_pos;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign emit_ok    = !out_valid_q || out_ready_i;

  always_comb begin
    cur_x = newer_x_q;
    cur_z = newer_z_q;
    nxt_x = in_x_q;
    nxt_z = in_z_q;
    prv_x = older_x_q;
    prv_z = older_z_q;
    unique case (opk_q)
      OP_CROSS_LAST: begin
        nxt_x = first_x_q;
        nxt_z = first_z_q;
      end
      OP_CROSS_FIRST: begin
        cur_x = first_x_q;
        cur_z = first_z_q;
        nxt_x = second_x_q;
        nxt_z = second_z_q;
        prv_x = newer_x_q;
        prv_z = newer_z_q;
      end
      default: begin
        cur_x = newer_x_q;
      end
    endcase
    if (opk_q == OP_AREA_EDGE || opk_q == OP_AREA_CLOSE) begin
      op_a_d = OP_W'(newer_x_q);
      op_b_d = (opk_q == OP_AREA_EDGE) ? OP_W'(in_z_q) : OP_W'(first_z_q);
      op_c_d = (opk_q == OP_AREA_EDGE) ? OP_W'(in_x_q) : OP_W'(first_x_q);
      op_d_d = OP_W'(newer_z_q);
    end else begin
      op_a_d = OP_W'(nxt_x) - OP_W'(cur_x);
      op_b_d = OP_W'(prv_z) - OP_W'(cur_z);
      op_c_d = OP_W'(nxt_z) - OP_W'(cur_z);
      op_d_d = OP_W'(prv_x) - OP_W'(cur_x);
    end
  end

  cpc_msub u_msub (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (op_a_q),
    .b_i     (op_b_q),
    .c_i     (op_c_q),
    .d_i     (op_d_q),
    .done_o  (msub_done),
    .diff_o  (msub_diff)
  );

  assign diff_flat = (msub_diff == '0);
  assign diff_pos  = !msub_diff[TERM_W-1] && !diff_flat;

  assign area_sum_full = SUM_W'(area_q) + SUM_W'(msub_diff);
  assign sum_top       = area_sum_full[SUM_W-1:AREA_W-1];

  always_comb begin
    if (sum_top != '0 && sum_top != '1) begin
      area_sat = area_sum_full[SUM_W-1] ? {1'b1, {(AREA_W-1){1'b0}}}
                                        : {1'b0, {(AREA_W-1){1'b1}}};
    end else begin
      area_sat = area_sum_full[AREA_W-1:0];
    end
  end

  cpc_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .note_i     (note),
    .flat_idx_o (flat_idx),
    .pos_idx_o  (pos_idx),
    .neg_idx_o  (neg_idx)
  );

  assign area_pos = !area_q[AREA_W-1] && (area_q != '0);
  assign opp_idx  = c0_pos_q ? neg_idx : pos_idx;

  always_comb begin
    if (area_q == '0) begin
      verdict = ST_ZERO_AREA;
    end else if (c0_flat_q) begin
      verdict = ST_COLLINEAR;
    end else if (flat_idx != NONE_IDX && flat_idx < opp_idx) begin
      verdict = ST_COLLINEAR;
    end else if (opp_idx != NONE_IDX) begin
      verdict = ST_NOT_CONVEX;
    end else begin
      verdict = ST_VALID;
    end
  end

  always_comb begin
    state_d     = state_q;
    opk_d       = opk_q;
    start_d     = 1'b0;
    count_d     = count_q;
    area_d      = area_q;
    c0_flat_d   = c0_flat_q;
    c0_pos_d    = c0_pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    area_out_d  = area_out_q;
    ccw_d       = ccw_q;
    note        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (count_q >= MAX_COUNT) begin
            count_d = SAT_COUNT;
            state_d = last_vertex_i ? S_FINISH : S_IDLE;
          end else if (count_q == '0) begin
            state_d = S_COMMIT;
          end else begin
            opk_d   = OP_AREA_EDGE;
            state_d = S_START;
          end
        end
      end
      S_START: begin
        start_d = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (msub_done) begin
          unique case (opk_q)
            OP_AREA_EDGE: begin
              area_d = area_sat;
              if (count_q >= IDX_W'(2)) begin
                opk_d   = OP_CROSS_MID;
                state_d = S_START;
              end else begin
                state_d = S_COMMIT;
              end
            end
            OP_CROSS_MID: begin
              note.note     = 1'b1;
              note.idx      = count_q - IDX_W'(1);
              note.flat     = diff_flat;
              note.positive = diff_pos;
              state_d       = S_COMMIT;
            end
            OP_AREA_CLOSE: begin
              area_d  = area_sat;
              opk_d   = OP_CROSS_LAST;
              state_d = S_START;
            end
            OP_CROSS_LAST: begin
              note.note     = 1'b1;
              note.idx      = count_q - IDX_W'(1);
              note.flat     = diff_flat;
              note.positive = diff_pos;
              opk_d         = OP_CROSS_FIRST;
              state_d       = S_START;
            end
            OP_CROSS_FIRST: begin
              c0_flat_d = diff_flat;
              c0_pos_d  = diff_pos;
              state_d   = S_VERDICT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_COMMIT: begin
        count_d = count_q + IDX_W'(1);
        state_d = last_q ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (count_q < MIN_VERTICES || count_q > MAX_COUNT) begin
          if (emit_ok) begin
            out_valid_d = 1'b1;
            status_d    = (count_q < MIN_VERTICES) ? ST_TOO_FEW : ST_TOO_MANY;
            area_out_d  = '0;
            ccw_d       = 1'b0;
            count_d     = '0;
            area_d      = '0;
            note.clear  = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          opk_d   = OP_AREA_CLOSE;
          state_d = S_START;
        end
      end
      S_VERDICT: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          status_d    = verdict;
          area_out_d  = area_q;
          ccw_d       = area_pos;
          count_d     = '0;
          area_d      = '0;
          note.clear  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      opk_q       <= OP_AREA_EDGE;
      start_q     <= 1'b0;
      count_q     <= '0;
      area_q      <= '0;
      c0_flat_q   <= 1'b0;
      c0_pos_q    <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= ST_VALID;
      area_out_q  <= '0;
      ccw_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      opk_q       <= opk_d;
      start_q     <= start_d;
      count_q     <= count_d;
      area_q      <= area_d;
      c0_flat_q   <= c0_flat_d;
      c0_pos_q    <= c0_pos_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      area_out_q  <= area_out_d;
      ccw_q       <= ccw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_x_q <= x_coord_i;
      in_z_q <= z_coord_i;
      last_q <= last_vertex_i;
    end
    if (state_q == S_START) begin
      op_a_q <= op_a_d;
      op_b_q <= op_b_d;
      op_c_q <= op_c_d;
      op_d_q <= op_d_d;
    end
    if (state_q == S_COMMIT) begin
      older_x_q <= newer_x_q;
      older_z_q <= newer_z_q;
      newer_x_q <= in_x_q;
      newer_z_q <= in_z_q;
      if (count_q == '0) begin
        first_x_q <= in_x_q;
        first_z_q <= in_z_q;
      end
      if (count_q == IDX_W'(1)) begin
        second_x_q <= in_x_q;
        second_z_q <= in_z_q;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign area_twice_o        = area_out_q;
  assign counter_clockwise_o = ccw_q;

  `ASSERT_PROP(a_done_in_wait, clk_i, rst_ni, msub_done |-> (state_q == S_WAIT),
    "product finished outside the wait state")
  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= SAT_COUNT,
    "vertex count beyond its saturation value")
  `ASSERT_PROP(a_cleared_on_result, clk_i, rst_ni,
    $rose(out_valid_q) |-> (count_q == '0 && area_q == '0),
    "polygon state not cleared when the result was registered")
  `ASSERT_PROP(a_no_area_on_reject, clk_i, rst_ni,
    (out_valid_q && (status_q == ST_TOO_FEW || status_q == ST_TOO_MANY ||
     status_q == ST_ZERO_AREA)) |-> (area_out_q == '0 && !ccw_q),
    "area reported with a rejecting status")

endmodule
